[rtl/click_long_press_event_fsm_assert.svh]
// Assertion macros for the click / long-press event block.
// Included by the modules that carry concurrent checks; no dependencies.
`ifndef CLICK_LONG_PRESS_EVENT_FSM_ASSERT_SVH
`define CLICK_LONG_PRESS_EVENT_FSM_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define CLPE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("click_long_press_event_fsm: assertion failed");
// next-cycle implication
`define CLPE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("click_long_press_event_fsm: assertion failed");
`else
`define CLPE_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define CLPE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[rtl/clpe_pkg.sv]
// Types and constants shared by the click / long-press event block.
// No dependencies.
package clpe_pkg;

    localparam int unsigned TICK_W  = 16;
    localparam int unsigned COUNT_W = 4;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [TICK_W-1:0]  TICK_MAX      = 16'hFFFF;
    localparam logic [COUNT_W-1:0] REPEAT_MAX    = 4'd15;
    localparam logic [TICK_W-1:0]  LONG_LIMIT_RST  = 16'd200;
    localparam logic [TICK_W-1:0]  SHORT_LIMIT_RST = 16'd30;

    localparam logic [CFG_IDX_W-1:0] REG_LONG_LIMIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_LIMIT = 2'd1;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_PRESSED = 3'd1,
        MODE_WAIT    = 3'd2,
        MODE_REPEAT  = 3'd3,
        MODE_LONG    = 3'd4
    } t_mode;

    typedef enum logic [2:0] {
        EV_NONE       = 3'd0,
        EV_DOWN       = 3'd1,
        EV_UP         = 3'd2,
        EV_REPEAT     = 3'd3,
        EV_SINGLE     = 3'd4,
        EV_DOUBLE     = 3'd5,
        EV_LONG_START = 3'd6,
        EV_LONG_HOLD  = 3'd7
    } t_event;

    typedef struct packed {
        t_mode               mode;
        logic [TICK_W-1:0]   tick;
        logic [COUNT_W-1:0]  repeat_cnt;
        t_event              held_event;
    } t_state;

    typedef struct packed {
        t_mode               machine_mode;
        logic [COUNT_W-1:0]  press_count;
        t_event              event_code;
    } t_result;

endpackage

[rtl/clpe_step.sv]
// Per-tick update of the press machine: tick counter, repeat count and event.
// Purely combinational; uses clpe_pkg.
module clpe_step (
    input  clpe_pkg::t_state                 i_state,
    input  logic                             i_held,
    input  logic [clpe_pkg::TICK_W-1:0]      i_long_limit,
    input  logic [clpe_pkg::TICK_W-1:0]      i_short_limit,
    output clpe_pkg::t_state                 o_state,
    output clpe_pkg::t_event                 o_event
);

    logic [clpe_pkg::TICK_W-1:0]  tick_inc;
    logic                         long_hit;
    logic                         short_over;
    logic                         short_under;
    clpe_pkg::t_mode              mode_nxt;
    logic [clpe_pkg::TICK_W-1:0]  tick_nxt;
    logic [clpe_pkg::COUNT_W-1:0] repeat_nxt;
    clpe_pkg::t_event             event_nxt;

    assign tick_inc = (i_state.mode != clpe_pkg::MODE_IDLE && i_state.tick != clpe_pkg::TICK_MAX)
                    ? i_state.tick + 16'd1 : i_state.tick;
    assign long_hit    = tick_inc > i_long_limit;
    assign short_over  = tick_inc > i_short_limit;
    assign short_under = tick_inc < i_short_limit;

    // next mode
    always_comb begin
        mode_nxt = i_state.mode;
        case (i_state.mode)
            clpe_pkg::MODE_IDLE: begin
                if (i_held) mode_nxt = clpe_pkg::MODE_PRESSED;
            end
            clpe_pkg::MODE_PRESSED: begin
                if (!i_held) mode_nxt = clpe_pkg::MODE_WAIT;
                else if (long_hit) mode_nxt = clpe_pkg::MODE_LONG;
            end
            clpe_pkg::MODE_WAIT: begin
                if (i_held) mode_nxt = clpe_pkg::MODE_REPEAT;
                else if (short_over) mode_nxt = clpe_pkg::MODE_IDLE;
            end
            clpe_pkg::MODE_REPEAT: begin
                if (!i_held) begin
                    mode_nxt = short_under ? clpe_pkg::MODE_WAIT : clpe_pkg::MODE_IDLE;
                end else if (short_over) begin
                    mode_nxt = clpe_pkg::MODE_PRESSED;
                end
            end
            clpe_pkg::MODE_LONG: begin
                if (!i_held) mode_nxt = clpe_pkg::MODE_IDLE;
            end
            default: begin
                mode_nxt = clpe_pkg::MODE_IDLE;
            end
        endcase
    end

    // tick, repeat count and event
    always_comb begin
        tick_nxt   = tick_inc;
        repeat_nxt = i_state.repeat_cnt;
        event_nxt  = i_state.held_event;
        case (i_state.mode)
            clpe_pkg::MODE_IDLE: begin
                if (i_held) begin
                    event_nxt  = clpe_pkg::EV_DOWN;
                    tick_nxt   = '0;
                    repeat_nxt = 4'd1;
                end else begin
                    event_nxt = clpe_pkg::EV_NONE;
                end
            end
            clpe_pkg::MODE_PRESSED: begin
                if (!i_held) begin
                    event_nxt = clpe_pkg::EV_UP;
                    tick_nxt  = '0;
                end else if (long_hit) begin
                    event_nxt = clpe_pkg::EV_LONG_START;
                end
            end
            clpe_pkg::MODE_WAIT: begin
                if (i_held) begin
                    if (i_state.repeat_cnt != clpe_pkg::REPEAT_MAX)
                        repeat_nxt = i_state.repeat_cnt + 4'd1;
                    event_nxt = clpe_pkg::EV_REPEAT;
                    tick_nxt  = '0;
                end else if (short_over) begin
                    if (i_state.repeat_cnt == 4'd1) event_nxt = clpe_pkg::EV_SINGLE;
                    else if (i_state.repeat_cnt == 4'd2) event_nxt = clpe_pkg::EV_DOUBLE;
                end
            end
            clpe_pkg::MODE_REPEAT: begin
                if (!i_held) begin
                    event_nxt = clpe_pkg::EV_UP;
                    if (short_under) tick_nxt = '0;
                end
            end
            clpe_pkg::MODE_LONG: begin
                event_nxt = i_held ? clpe_pkg::EV_LONG_HOLD : clpe_pkg::EV_UP;
            end
            default: begin
                event_nxt = i_state.held_event;
            end
        endcase
    end

    assign o_event                = event_nxt;
    assign o_state.mode           = mode_nxt;
    assign o_state.tick           = tick_nxt;
    assign o_state.repeat_cnt     = repeat_nxt;
    assign o_state.held_event     = event_nxt;

endmodule

[rtl/clpe_skid.sv]
// Two-entry output stage: result register plus skid register.
// Uses clpe_pkg::t_result and the assertion macros header.
`include "click_long_press_event_fsm_assert.svh"

module clpe_skid (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  clpe_pkg::t_result  i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output clpe_pkg::t_result  o_data
);

    logic              r_out_valid;
    logic              r_skid_valid;
    clpe_pkg::t_result r_out;
    clpe_pkg::t_result r_skid;
    logic              n_out_valid;
    logic              n_skid_valid;
    logic              accept;
    logic              drain;

    assign o_ready = !r_skid_valid;
    assign accept  = i_valid && !r_skid_valid;
    assign drain   = !r_out_valid || i_ready;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        if (drain) begin
            n_out_valid  = r_skid_valid || accept;
            n_skid_valid = 1'b0;
        end else if (accept) begin
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (drain) begin
            r_out <= r_skid_valid ? r_skid : i_data;
        end else if (accept) begin
            r_skid <= i_data;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    `CLPE_ASSERT_NOW(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `CLPE_ASSERT_NEXT(a_stall_fills_skid, i_clk, i_rst_n, accept && r_out_valid && !i_ready, r_skid_valid)
    `CLPE_ASSERT_NEXT(a_drain_empties, i_clk, i_rst_n, r_out_valid && i_ready && !r_skid_valid && !accept, !r_out_valid)

endmodule

[rtl/click_long_press_event_fsm.sv]
// Top level of the click / double-click / long-press event block.
// Uses clpe_pkg, clpe_step, clpe_skid and the assertion macros header.
//
//  channel   direction  handshake                   payload
//  s_axis    in         s_axis_tvalid/tready        tdata[0] combo_held, [1] consume_event
//  m_axis    out        m_axis_tvalid/tready        tdata[2:0] event, [6:3] count, [9:7] mode
//  cfg       in         i_cfg_valid/o_cfg_ready     i_cfg_index, i_cfg_data
//
// One tick per cycle unless the skid register is full; each tick is one pass through clpe_step.
// Its result lands on the edge taking it: output register, or skid register if stalled.
// A two-entry output stage keeps the input open for one tick while a result is stalled.
// Synchronous active-low reset clears the machine and loads limits 200 and 30.
// Config writes take effect on the next tick; the config port is always ready.
`include "click_long_press_event_fsm_assert.svh"

module click_long_press_event_fsm (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] combo_held, [1] consume_event
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [2:0] event_code, [6:3] press_count, [9:7] machine_mode
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [clpe_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [clpe_pkg::TICK_W-1:0]    i_cfg_data
);

    clpe_pkg::t_state             r_state;
    logic [clpe_pkg::TICK_W-1:0]  r_long_limit;
    logic [clpe_pkg::TICK_W-1:0]  r_short_limit;
    clpe_pkg::t_state             w_step;
    clpe_pkg::t_event             w_event;
    clpe_pkg::t_state             n_state;
    clpe_pkg::t_result            w_res;
    clpe_pkg::t_result            w_out;
    logic                         in_xfer;
    logic                         held;
    logic                         consume;

    assign held    = s_axis_tdata[0];
    assign consume = s_axis_tdata[1];
    assign in_xfer = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready = 1'b1;

    clpe_step u_step (
        .i_state       (r_state),
        .i_held        (held),
        .i_long_limit  (r_long_limit),
        .i_short_limit (r_short_limit),
        .o_state       (w_step),
        .o_event       (w_event)
    );

    always_comb begin
        n_state = w_step;
        if (consume) n_state.held_event = clpe_pkg::EV_NONE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode       <= clpe_pkg::MODE_IDLE;
            r_state.tick       <= '0;
            r_state.repeat_cnt <= '0;
            r_state.held_event <= clpe_pkg::EV_NONE;
        end else if (in_xfer) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_limit  <= clpe_pkg::LONG_LIMIT_RST;
            r_short_limit <= clpe_pkg::SHORT_LIMIT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                clpe_pkg::REG_LONG_LIMIT:  r_long_limit  <= i_cfg_data;
                clpe_pkg::REG_SHORT_LIMIT: r_short_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_res.machine_mode = w_step.mode;
    assign w_res.press_count  = w_step.repeat_cnt;
    assign w_res.event_code   = w_event;

    clpe_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (w_res),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (w_out)
    );

    assign m_axis_tdata = {6'd0, w_out.machine_mode, w_out.press_count, w_out.event_code};

    `CLPE_ASSERT_NOW(a_count_when_active, i_clk, i_rst_n, r_state.mode != clpe_pkg::MODE_IDLE, r_state.repeat_cnt != '0)
    `CLPE_ASSERT_NOW(a_down_in_pressed, i_clk, i_rst_n, r_state.held_event == clpe_pkg::EV_DOWN, r_state.mode == clpe_pkg::MODE_PRESSED)
    `CLPE_ASSERT_NOW(a_hold_in_long, i_clk, i_rst_n, r_state.held_event == clpe_pkg::EV_LONG_HOLD, r_state.mode == clpe_pkg::MODE_LONG)

endmodule

[dv/tb_top.sv]
// Testbench for click_long_press_event_fsm: directed and random key-hold ticks,
// checked result by result against a behavioral model of the press machine.
// Depends on rtl/clpe_pkg.sv and rtl/click_long_press_event_fsm.sv.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 2_000_000;
    localparam logic [clpe_pkg::CFG_IDX_W-1:0] REG_UNUSED_2 = 2'd2;
    localparam logic [clpe_pkg::CFG_IDX_W-1:0] REG_UNUSED_3 = 2'd3;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [0] combo_held, [1] consume_event
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // [2:0] event_code, [6:3] press_count, [9:7] machine_mode
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [clpe_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [clpe_pkg::TICK_W-1:0]    i_cfg_data;

    // model of the press machine
    logic [clpe_pkg::TICK_W-1:0]  press_long_limit;
    logic [clpe_pkg::TICK_W-1:0]  press_short_limit;
    clpe_pkg::t_mode              fsm_mode;
    logic [clpe_pkg::TICK_W-1:0]  fsm_ticks;
    logic [clpe_pkg::COUNT_W-1:0] fsm_repeats;
    clpe_pkg::t_event             fsm_event;

    clpe_pkg::t_result expected_events[$];
    int unsigned mismatch_count;
    int unsigned cycle_count;
    int unsigned ticks_sent;
    bit          gaps_on;
    bit          stalls_on;
    int unsigned rx_hold_cycles;

    click_long_press_event_fsm dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // one tick of the press machine; queues the result it reports
    function automatic void press_machine_step(input bit held, input bit consume);
        clpe_pkg::t_result r;
        if (fsm_mode != clpe_pkg::MODE_IDLE && fsm_ticks != clpe_pkg::TICK_MAX) fsm_ticks++;
        case (fsm_mode)
            clpe_pkg::MODE_IDLE: begin
                if (held) begin
                    fsm_event   = clpe_pkg::EV_DOWN;
                    fsm_ticks   = '0;
                    fsm_repeats = 4'd1;
                    fsm_mode    = clpe_pkg::MODE_PRESSED;
                end else begin
                    fsm_event = clpe_pkg::EV_NONE;
                end
            end
            clpe_pkg::MODE_PRESSED: begin
                if (!held) begin
                    fsm_event = clpe_pkg::EV_UP;
                    fsm_ticks = '0;
                    fsm_mode  = clpe_pkg::MODE_WAIT;
                end else if (fsm_ticks > press_long_limit) begin
                    fsm_event = clpe_pkg::EV_LONG_START;
                    fsm_mode  = clpe_pkg::MODE_LONG;
                end
            end
            clpe_pkg::MODE_WAIT: begin
                if (held) begin
                    if (fsm_repeats != clpe_pkg::REPEAT_MAX) fsm_repeats++;
                    fsm_event = clpe_pkg::EV_REPEAT;
                    fsm_ticks = '0;
                    fsm_mode  = clpe_pkg::MODE_REPEAT;
                end else if (fsm_ticks > press_short_limit) begin
                    if (fsm_repeats == 4'd1) fsm_event = clpe_pkg::EV_SINGLE;
                    else if (fsm_repeats == 4'd2) fsm_event = clpe_pkg::EV_DOUBLE;
                    fsm_mode = clpe_pkg::MODE_IDLE;
                end
            end
            clpe_pkg::MODE_REPEAT: begin
                if (!held) begin
                    fsm_event = clpe_pkg::EV_UP;
                    if (fsm_ticks < press_short_limit) begin
                        fsm_ticks = '0;
                        fsm_mode  = clpe_pkg::MODE_WAIT;
                    end else begin
                        fsm_mode = clpe_pkg::MODE_IDLE;
                    end
                end else if (fsm_ticks > press_short_limit) begin
                    fsm_mode = clpe_pkg::MODE_PRESSED;
                end
            end
            clpe_pkg::MODE_LONG: begin
                if (held) begin
                    fsm_event = clpe_pkg::EV_LONG_HOLD;
                end else begin
                    fsm_event = clpe_pkg::EV_UP;
                    fsm_mode  = clpe_pkg::MODE_IDLE;
                end
            end
            default: fsm_mode = clpe_pkg::MODE_IDLE;
        endcase
        r.event_code   = fsm_event;
        r.press_count  = fsm_repeats;
        r.machine_mode = fsm_mode;
        expected_events.push_back(r);
        if (consume) fsm_event = clpe_pkg::EV_NONE;
        ticks_sent++;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (mismatch_count < 100)
            $display("[%0t] mismatch %s: got %0d want %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin : check_results
        clpe_pkg::t_result got;
        clpe_pkg::t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = clpe_pkg::t_result'(m_axis_tdata[9:0]);
            if (expected_events.size() == 0) begin
                report_mismatch("result with nothing expected", m_axis_tdata, 0);
            end else begin
                want = expected_events.pop_front();
                if (got.event_code != want.event_code)
                    report_mismatch("event_code", got.event_code, want.event_code);
                if (got.press_count != want.press_count)
                    report_mismatch("press_count", got.press_count, want.press_count);
                if (got.machine_mode != want.machine_mode)
                    report_mismatch("machine_mode", got.machine_mode, want.machine_mode);
                if (m_axis_tdata[15:10] != '0)
                    report_mismatch("tdata padding", m_axis_tdata[15:10], 0);
            end
        end
    end

    // receiver: random stall bursts, plus long hold-offs on request
    initial begin : result_sink
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_cycles != 0) begin
                m_axis_tready <= 1'b0;
                repeat (rx_hold_cycles - 1) @(posedge i_clk);
                rx_hold_cycles = 0;
            end else if (stalls_on && $urandom_range(4) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(0, 18)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic send_tick(input bit held, input bit consume);
        if (gaps_on && $urandom_range(4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, consume, held};
        do @(posedge i_clk); while (!s_axis_tready);
        press_machine_step(held, consume);
    endtask

    task automatic send_run(input bit held, input int count);
        repeat (count) send_tick(held, $urandom_range(3) == 0);
    endtask

    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        while (expected_events.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [clpe_pkg::CFG_IDX_W-1:0] index,
                               input logic [clpe_pkg::TICK_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        if (index == clpe_pkg::REG_LONG_LIMIT) press_long_limit = value;
        else if (index == clpe_pkg::REG_SHORT_LIMIT) press_short_limit = value;
    endtask

    task automatic set_limits(input logic [clpe_pkg::TICK_W-1:0] long_lim,
                              input logic [clpe_pkg::TICK_W-1:0] short_lim);
        wait_for_results();
        write_limit(clpe_pkg::REG_LONG_LIMIT, long_lim);
        write_limit(clpe_pkg::REG_SHORT_LIMIT, short_lim);
    endtask

    // press/release sequences shaped around the current limits, some noise
    task automatic random_presses(input int n_items);
        int stop_at;
        int hold_len;
        int rel_len;
        int short_span;
        int long_span;
        stop_at    = ticks_sent + n_items;
        short_span = (press_short_limit > 40) ? 40 : int'(press_short_limit);
        long_span  = int'(press_long_limit);
        while (ticks_sent < stop_at) begin
            if ($urandom_range(9) == 0) begin
                repeat ($urandom_range(1, 8))
                    send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
            end else begin
                case ($urandom_range(3))
                    0: hold_len = (long_span <= 250) ?
                           $urandom_range((long_span > 1) ? long_span - 1 : 1, long_span + 4) :
                           $urandom_range(1, 40);
                    1: hold_len = $urandom_range(1, short_span + 3);
                    default: hold_len = $urandom_range(1, 3);
                endcase
                send_run(1'b1, hold_len);
                if ($urandom_range(1) == 0) rel_len = $urandom_range(1, short_span + 1);
                else rel_len = $urandom_range(short_span, short_span + 4);
                send_run(1'b0, rel_len);
            end
        end
    endtask

    // limits as loaded by reset: a click times out to single after 31 quiet ticks
    task automatic test_reset_limits();
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        send_run(1'b0, 32);
    endtask

    task automatic test_event_kinds();
        set_limits(16'd3, 16'd2);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        // long press start, long hold, release
        send_tick(1'b1, 1'b0);
        repeat (4) send_tick(1'b1, 1'b0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        // single click, down event consumed
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b0);
        repeat (3) send_tick(1'b0, 1'b0);
        // double click
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        // repeat press held past the short limit, back to pressed and long start
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        repeat (6) send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        // repeat press released late goes straight to idle
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        repeat (3) send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
    endtask

    task automatic test_unused_config_index();
        set_limits(16'd6, 16'd3);
        write_limit(REG_UNUSED_2, 16'h0000);
        write_limit(REG_UNUSED_3, 16'hFFFF);
        send_tick(1'b1, 1'b0);
        send_run(1'b1, 8);
        send_tick(1'b0, 1'b0);
        send_run(1'b0, 5);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        send_run(1'b0, 5);
    endtask

    task automatic test_repeat_saturation();
        set_limits(16'd50, 16'd4);
        send_tick(1'b1, 1'b0);
        repeat (18) begin
            send_tick(1'b0, 1'b0);
            send_tick(1'b1, 1'b0);
        end
        send_tick(1'b0, 1'b0);
        send_run(1'b0, 7);
    endtask

    task automatic test_backpressure();
        set_limits(16'd8, 16'd3);
        gaps_on = 1'b0;
        rx_hold_cycles = 80;
        random_presses(40);
        // sender holds back until everything is out
        wait_for_results();
        gaps_on = 1'b1;
        random_presses(20);
    endtask

    task automatic test_random_limits();
        set_limits(16'd0, 16'd0);
        random_presses(150);
        set_limits(16'hFFFF, 16'hFFFF);
        random_presses(100);
        set_limits(16'd1, 16'd5);
        random_presses(150);
        set_limits(clpe_pkg::LONG_LIMIT_RST, clpe_pkg::SHORT_LIMIT_RST);
        random_presses(150);
        repeat (2) begin
            set_limits(16'($urandom_range(0, 40)), 16'($urandom_range(0, 12)));
            random_presses(150);
        end
    endtask

    task automatic test_steady_tail();
        set_limits(16'($urandom_range(2, 20)), 16'($urandom_range(1, 8)));
        random_presses(300);
    endtask

    initial begin
        i_rst_n           = 1'b0;
        s_axis_tvalid     = 1'b0;
        s_axis_tdata      = '0;
        i_cfg_valid       = 1'b0;
        i_cfg_index       = '0;
        i_cfg_data        = '0;
        cycle_count       = 0;
        mismatch_count    = 0;
        ticks_sent        = 0;
        rx_hold_cycles    = 0;
        gaps_on           = 1'b0;
        stalls_on         = 1'b0;
        press_long_limit  = clpe_pkg::LONG_LIMIT_RST;
        press_short_limit = clpe_pkg::SHORT_LIMIT_RST;
        fsm_mode          = clpe_pkg::MODE_IDLE;
        fsm_ticks         = '0;
        fsm_repeats       = '0;
        fsm_event         = clpe_pkg::EV_NONE;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        test_reset_limits();
        test_event_kinds();
        test_unused_config_index();
        test_repeat_saturation();
        test_backpressure();
        test_random_limits();

        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        test_steady_tail();

        wait_for_results();
        repeat (16) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule

[click_long_press_event_fsm.f]
+incdir+rtl
rtl/clpe_pkg.sv
rtl/clpe_step.sv
rtl/clpe_skid.sv
rtl/click_long_press_event_fsm.sv
dv/tb_top.sv
